@@ sv/otep_pkg.sv @@
// Shared types and constants of the TCP option extension parser.
// No dependencies; compiled first.
`default_nettype none

package otep_pkg;

   localparam int DEFAULT_MAX_OPTION_BYTES = 40;

   localparam int BYTE_W   = 8;
   localparam int LEN_W    = 6;
   localparam int STATUS_W = 3;
   localparam int WORD_W   = 32;
   localparam int PORT_W   = 16;
   localparam int PRIO_W   = 4;
   localparam int MAGIC_W  = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_OPTION_KIND       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_MAGIC     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NEW_PATH_MAGIC    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_MIN_AREA  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_NEW_PATH_MIN_AREA = 3'd4;

   localparam logic [BYTE_W-1:0]  RST_OPTION_KIND       = 8'd253;
   localparam logic [MAGIC_W-1:0] RST_INITIAL_MAGIC     = 16'd1;
   localparam logic [MAGIC_W-1:0] RST_NEW_PATH_MAGIC    = 16'd2;
   localparam logic [LEN_W-1:0]   RST_INITIAL_MIN_AREA  = 6'd8;
   localparam logic [LEN_W-1:0]   RST_NEW_PATH_MIN_AREA = 6'd11;

   localparam logic [STATUS_W-1:0] STATUS_NONE    = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_ID      = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_PATH    = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_SHORT   = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_AREA    = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_OVERRUN = 3'd5;

   localparam logic [BYTE_W-1:0] CREATE_BIT = 8'h08;

   localparam logic [6:0] ID_RECORD_BYTES   = 7'd8;
   localparam logic [6:0] PATH_RECORD_BYTES = 7'd11;

   typedef struct packed {
      logic [BYTE_W-1:0]  option_kind;
      logic [MAGIC_W-1:0] initial_magic;
      logic [MAGIC_W-1:0] new_path_magic;
      logic [LEN_W-1:0]   initial_min_area;
      logic [LEN_W-1:0]   new_path_min_area;
   } cfg_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [WORD_W-1:0]   conn_id;
      logic [WORD_W-1:0]   path_address;
      logic [PORT_W-1:0]   path_port;
      logic [PRIO_W-1:0]   path_priority;
      logic                path_create;
   } result_type;

endpackage

`default_nettype wire

@@ sv/otep_req_if.sv @@
// Request channel: one options byte per beat with area length and first mark.
// Depends on otep_pkg.
`default_nettype none

interface otep_req_if import otep_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] opt_byte;
   logic [LEN_W-1:0]  area_len;
   logic              first;

   modport source (output valid, opt_byte, area_len, first, input ready);
   modport sink (input valid, opt_byte, area_len, first, output ready);
endinterface

`default_nettype wire

@@ sv/otep_rsp_if.sv @@
// Response channel: one parse result per beat.
// Depends on otep_pkg.
`default_nettype none

interface otep_rsp_if import otep_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [WORD_W-1:0]   conn_id;
   logic [WORD_W-1:0]   path_address;
   logic [PORT_W-1:0]   path_port;
   logic [PRIO_W-1:0]   path_priority;
   logic                path_create;

   modport source (output valid, status, conn_id, path_address, path_port,
                   path_priority, path_create, input ready);
   modport sink (input valid, status, conn_id, path_address, path_port,
                 path_priority, path_create, output ready);
endinterface

`default_nettype wire

@@ sv/tcp_option_extension_parser.sv @@
// Top level of the TCP option extension parser: beat registers around the walker.
// Depends on otep_pkg, otep_req_if, otep_rsp_if, otep_csr, otep_walker.
//
//   channel  dir  beat contents
//   req      in   opt_byte, area_len, first
//   rsp      out  status, conn_id, path_address, path_port, path_priority, path_create
//   csr      in   csr_wr_en, csr_index, csr_wr_data (write only)
//
// One options byte per cycle while rsp is not stalled; the area's last byte passes the
// input register, the walker logic and the result register before the result is valid.
// Synchronous reset clears the parser and loads the register defaults.
// A stalled rsp blocks req only while a result is waiting and the held byte ends an area.
`default_nettype none

module tcp_option_extension_parser import otep_pkg::*; #(
   parameter int MAX_OPTION_BYTES = DEFAULT_MAX_OPTION_BYTES
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   otep_req_if.sink                   req_chan,
   otep_rsp_if.source                 rsp_chan,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wr_data
);

   cfg_type           cfg;
   logic              in_vld_ff;
   logic [BYTE_W-1:0] in_byte_ff;
   logic [LEN_W-1:0]  in_len_ff;
   logic              in_first_ff;
   logic              rsp_vld_ff;
   result_type        rsp_data_ff;
   result_type        result;
   logic              emit;
   logic              advance;
   logic              req_take;

   otep_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   otep_walker #(
      .MAX_OPTION_BYTES (MAX_OPTION_BYTES)
   ) u_walker (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .step     (advance),
      .in_byte  (in_byte_ff),
      .in_len   (in_len_ff),
      .in_first (in_first_ff),
      .emit     (emit),
      .result   (result)
   );

   assign advance = in_vld_ff && (!emit || !rsp_vld_ff || rsp_chan.ready);
   assign req_chan.ready = !in_vld_ff || advance;
   assign req_take = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_take) begin
         in_vld_ff <= 1'b1;
      end else if (advance) begin
         in_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff  <= req_chan.opt_byte;
         in_len_ff   <= req_chan.area_len;
         in_first_ff <= req_chan.first;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance && emit) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_chan.valid         = rsp_vld_ff;
   assign rsp_chan.status        = rsp_data_ff.status;
   assign rsp_chan.conn_id       = rsp_data_ff.conn_id;
   assign rsp_chan.path_address  = rsp_data_ff.path_address;
   assign rsp_chan.path_port     = rsp_data_ff.path_port;
   assign rsp_chan.path_priority = rsp_data_ff.path_priority;
   assign rsp_chan.path_create   = rsp_data_ff.path_create;

endmodule

`default_nettype wire

@@ sv/otep_csr.sv @@
// Configuration register bank of the option parser.
// Depends on otep_pkg.
`default_nettype none

module otep_csr import otep_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wr_data,
   output      cfg_type               cfg
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.option_kind       <= RST_OPTION_KIND;
         cfg_ff.initial_magic     <= RST_INITIAL_MAGIC;
         cfg_ff.new_path_magic    <= RST_NEW_PATH_MAGIC;
         cfg_ff.initial_min_area  <= RST_INITIAL_MIN_AREA;
         cfg_ff.new_path_min_area <= RST_NEW_PATH_MIN_AREA;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_OPTION_KIND:       cfg_ff.option_kind       <= csr_wr_data[BYTE_W-1:0];
            CSR_INITIAL_MAGIC:     cfg_ff.initial_magic     <= csr_wr_data;
            CSR_NEW_PATH_MAGIC:    cfg_ff.new_path_magic    <= csr_wr_data;
            CSR_INITIAL_MIN_AREA:  cfg_ff.initial_min_area  <= csr_wr_data[LEN_W-1:0];
            CSR_NEW_PATH_MIN_AREA: cfg_ff.new_path_min_area <= csr_wr_data[LEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ sv/otep_walker.sv @@
// Option walker: parse state and the per-byte next-state and result logic.
// Depends on otep_pkg.
`default_nettype none

module otep_walker import otep_pkg::*; #(
   parameter int MAX_OPTION_BYTES = DEFAULT_MAX_OPTION_BYTES
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cfg_type           cfg,
   input  wire logic              step,
   input  wire logic [BYTE_W-1:0] in_byte,
   input  wire logic [LEN_W-1:0]  in_len,
   input  wire logic              in_first,
   output      logic              emit,
   output      result_type        result
);

   localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_OPTION_BYTES);

   typedef enum logic [2:0] {
      PH_KIND, PH_LEN, PH_MAGIC_LO, PH_MAGIC_HI, PH_RECORD, PH_DONE
   } phase_type;

   typedef struct packed {
      logic [LEN_W-1:0]    pos;
      logic [LEN_W-1:0]    next_at;
      logic [LEN_W-1:0]    start;
      logic [BYTE_W-1:0]   olen;
      phase_type           phase;
      logic                stopped;
      logic [BYTE_W-1:0]   magic_lo;
      logic [WORD_W-1:0]   word;
      logic [PORT_W-1:0]   port;
      logic [BYTE_W-1:0]   flag;
      logic [STATUS_W-1:0] status;
   } parse_state_type;

   function automatic parse_state_type clear_state();
      parse_state_type r;
      r = '0;
      r.phase = PH_KIND;
      return r;
   endfunction

   function automatic parse_state_type halt_walk(input parse_state_type s,
                                                 input logic [STATUS_W-1:0] code);
      parse_state_type r;
      r = s;
      r.status = code;
      r.stopped = 1'b1;
      r.phase = PH_KIND;
      return r;
   endfunction

   function automatic parse_state_type kind_step(input parse_state_type s,
                                                 input logic [LEN_W-1:0] p,
                                                 input logic [BYTE_W-1:0] b,
                                                 input logic [LEN_W-1:0] len);
      parse_state_type r;
      logic [LEN_W:0]  p_next;
      r = s;
      p_next = {1'b0, p} + 7'd1;
      if (p == s.next_at) begin
         if (b == 8'd0) begin
            r = halt_walk(s, STATUS_NONE);
         end else if (b == 8'd1) begin
            r.next_at = p_next[LEN_W-1:0];
         end else begin
            r.start = p;
            r.flag = b;
            if (p_next >= {1'b0, len}) r = halt_walk(r, STATUS_NONE);
            else r.phase = PH_LEN;
         end
      end
      return r;
   endfunction

   function automatic parse_state_type len_step(input parse_state_type s,
                                                input logic [BYTE_W-1:0] b,
                                                input logic [LEN_W-1:0] len,
                                                input logic [BYTE_W-1:0] kind);
      parse_state_type r;
      logic [8:0]      end_at;
      logic [LEN_W:0]  end4;
      r = s;
      r.olen = b;
      end_at = {3'b0, s.start} + {1'b0, b};
      end4 = {1'b0, s.start} + 7'd4;
      if (end_at > {3'b0, len} || b < 8'd2) begin
         r = halt_walk(r, STATUS_NONE);
      end else if (s.flag == kind) begin
         if (end4 > {1'b0, len}) r = halt_walk(r, STATUS_SHORT);
         else r.phase = PH_MAGIC_LO;
      end else begin
         r.next_at = end_at[LEN_W-1:0];
         r.phase = PH_KIND;
      end
      return r;
   endfunction

   function automatic parse_state_type follow_step(input parse_state_type s,
                                                   input logic [LEN_W-1:0] p,
                                                   input logic [BYTE_W-1:0] b,
                                                   input logic [LEN_W-1:0] len,
                                                   input logic [BYTE_W-1:0] kind);
      parse_state_type r;
      r = s;
      if (!s.stopped) begin
         if (s.phase == PH_KIND) r = kind_step(s, p, b, len);
         else if (s.phase == PH_LEN) r = len_step(s, b, len, kind);
      end
      return r;
   endfunction

   parse_state_type     st_ff;
   parse_state_type     st_in;
   parse_state_type     w;
   logic [LEN_W-1:0]    len_c;
   logic                go;
   logic                last;
   logic [LEN_W-1:0]    p;
   logic [LEN_W-1:0]    off;
   logic [MAGIC_W-1:0]  m;
   logic                is_init;
   logic                is_path;
   logic [LEN_W:0]      rec_end;
   logic [STATUS_W-1:0] st_code;

   always_comb begin
      len_c = (in_len > MaxLen) ? MaxLen : in_len;
      w = in_first ? clear_state() : st_ff;
      go = (in_first || st_ff.phase != PH_DONE) && (len_c != '0);
      p = w.pos;
      off = p - w.start;
      m = {in_byte, w.magic_lo};
      is_init = (m == cfg.initial_magic);
      is_path = (m == cfg.new_path_magic);
      rec_end = {1'b0, w.start} + (is_init ? ID_RECORD_BYTES : PATH_RECORD_BYTES);
      last = ({1'b0, p} + 7'd1) >= {1'b0, len_c};
      emit = 1'b0;
      result = '0;
      st_code = STATUS_NONE;

      if (go && !w.stopped) begin
         unique case (w.phase)
            PH_KIND: w = kind_step(w, p, in_byte, len_c);
            PH_LEN: w = len_step(w, in_byte, len_c, cfg.option_kind);
            PH_MAGIC_LO: begin
               w.magic_lo = in_byte;
               w.phase = PH_MAGIC_HI;
            end
            PH_MAGIC_HI: begin
               if ((is_init && cfg.initial_min_area > len_c) ||
                   (is_path && cfg.new_path_min_area > len_c)) begin
                  w = halt_walk(w, STATUS_AREA);
               end else if (is_init || is_path) begin
                  if (rec_end > {1'b0, len_c}) begin
                     w = halt_walk(w, STATUS_OVERRUN);
                  end else begin
                     w.status = is_init ? STATUS_ID : STATUS_PATH;
                     w.word = '0;
                     w.port = '0;
                     w.phase = PH_RECORD;
                  end
               end else begin
                  w.phase = PH_KIND;
                  w.next_at = w.start + w.olen[LEN_W-1:0];
                  if (w.olen == 8'd2) begin
                     w = kind_step(w, w.start + 6'd2, w.magic_lo, len_c);
                     w = follow_step(w, p, in_byte, len_c, cfg.option_kind);
                  end else if (w.olen == 8'd3) begin
                     w = kind_step(w, p, in_byte, len_c);
                  end
               end
            end
            PH_RECORD: begin
               if (w.status == STATUS_ID) begin
                  w.word = {w.word[WORD_W-BYTE_W-1:0], in_byte};
                  if (off >= 6'd7) begin
                     w.stopped = 1'b1;
                     w.phase = PH_KIND;
                  end
               end else if (off <= 6'd7) begin
                  w.word = {in_byte, w.word[WORD_W-1:BYTE_W]};
               end else if (off == 6'd8) begin
                  w.port = {8'h00, in_byte};
               end else if (off == 6'd9) begin
                  w.port = w.port | {in_byte, 8'h00};
               end else begin
                  w.flag = in_byte;
                  w.stopped = 1'b1;
                  w.phase = PH_KIND;
               end
            end
            default: begin
            end
         endcase
      end

      if (go) begin
         if (!last) begin
            w.pos = p + 6'd1;
         end else begin
            emit = 1'b1;
            st_code = (!w.stopped && w.phase == PH_RECORD) ? STATUS_OVERRUN : w.status;
            result.status = st_code;
            if (st_code == STATUS_ID) result.conn_id = w.word;
            if (st_code == STATUS_PATH) begin
               result.path_address = w.word;
               result.path_port = w.port;
               result.path_priority = w.flag[BYTE_W-1:BYTE_W-PRIO_W];
               result.path_create = |(w.flag & CREATE_BIT);
            end
            w.phase = PH_DONE;
         end
      end
      st_in = w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= clear_state();
      end else if (step) begin
         st_ff <= st_in;
      end
   end

endmodule

`default_nettype wire

@@ tb/sv/tcp_option_extension_parser_test.sv @@
// Testbench for tcp_option_extension_parser: streams TCP options areas one byte per beat,
// predicts each parse result in step with the input and checks result beats in order.
// Depends on otep_pkg, otep_req_if, otep_rsp_if and the parser RTL.
module tcp_option_extension_parser_test;
   timeunit 1ns;
   timeprecision 1ps;
   import otep_pkg::*;

   localparam int SETTLE_CYCLES = 8;
   localparam int MAX_GAP = 17;
   localparam int RANDOM_BYTES = 850;
   localparam int DIRECTED_BYTES = 25;
   localparam int REPORT_LIMIT = 10;
   localparam logic [BYTE_W-1:0] OPT_END = 8'd0;
   localparam logic [BYTE_W-1:0] OPT_NOP = 8'd1;

   typedef enum logic [2:0] {
      WALK_KIND, WALK_LEN, WALK_MAGIC_LO, WALK_MAGIC_HI, WALK_RECORD, WALK_DONE
   } walk_phase_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   otep_req_if req_bus ();
   otep_rsp_if rsp_bus ();

   tcp_option_extension_parser dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   cfg_type        parser_cfg;
   logic [5:0]     walk_pos, next_kind_at, opt_start;
   logic [7:0]     opt_len, flag_acc;
   walk_phase_type walk_phase;
   logic           walk_halted;
   logic [15:0]    magic_acc, port_acc;
   logic [31:0]    word_acc;
   logic [2:0]     status_acc;

   result_type expected_results[$];
   int  bytes_sent = 0;
   int  fault_count = 0;
   bit  steady_flow = 1'b0;

   function automatic void clear_walker();
      walk_pos = '0;
      next_kind_at = '0;
      opt_start = '0;
      opt_len = '0;
      walk_phase = WALK_KIND;
      walk_halted = 1'b0;
      magic_acc = '0;
      word_acc = '0;
      port_acc = '0;
      flag_acc = '0;
      status_acc = STATUS_NONE;
   endfunction

   function automatic void halt_walk(input logic [2:0] code);
      status_acc = code;
      walk_halted = 1'b1;
      walk_phase = WALK_KIND;
   endfunction

   // Returns 2 or 3 when the bytes from that offset of an unknown option must be walked again.
   function automatic int walk_one(input int unsigned p, input logic [7:0] b,
                                   input int unsigned lim);
      int unsigned s, off, need;
      logic [15:0] m;
      s = opt_start;
      if (walk_halted)
         return 0;
      case (walk_phase)
         WALK_KIND: begin
            if (p != next_kind_at)
               return 0;
            if (b == OPT_END) begin
               halt_walk(STATUS_NONE);
            end else if (b == OPT_NOP) begin
               next_kind_at = 6'(p + 1);
            end else begin
               opt_start = 6'(p);
               flag_acc = b;
               if (p + 1 >= lim)
                  halt_walk(STATUS_NONE);
               else
                  walk_phase = WALK_LEN;
            end
         end
         WALK_LEN: begin
            opt_len = b;
            if (s + b > lim || b < 2) begin
               halt_walk(STATUS_NONE);
            end else if (flag_acc == parser_cfg.option_kind) begin
               if (s + 4 > lim)
                  halt_walk(STATUS_SHORT);
               else
                  walk_phase = WALK_MAGIC_LO;
            end else begin
               next_kind_at = 6'(s + b);
               walk_phase = WALK_KIND;
            end
         end
         WALK_MAGIC_LO: begin
            magic_acc = {8'h00, b};
            walk_phase = WALK_MAGIC_HI;
         end
         WALK_MAGIC_HI: begin
            m = {b, magic_acc[7:0]};
            magic_acc = m;
            if ((m == parser_cfg.initial_magic && parser_cfg.initial_min_area > lim) ||
                (m == parser_cfg.new_path_magic && parser_cfg.new_path_min_area > lim)) begin
               halt_walk(STATUS_AREA);
               return 0;
            end
            if (m == parser_cfg.initial_magic || m == parser_cfg.new_path_magic) begin
               need = (m == parser_cfg.initial_magic) ? ID_RECORD_BYTES : PATH_RECORD_BYTES;
               if (s + need > lim) begin
                  halt_walk(STATUS_OVERRUN);
                  return 0;
               end
               status_acc = (m == parser_cfg.initial_magic) ? STATUS_ID : STATUS_PATH;
               word_acc = '0;
               port_acc = '0;
               walk_phase = WALK_RECORD;
               return 0;
            end
            walk_phase = WALK_KIND;
            next_kind_at = 6'(s + opt_len);
            if (opt_len == 2)
               return 2;
            if (opt_len == 3)
               return 3;
         end
         WALK_RECORD: begin
            off = p - s;
            if (status_acc == STATUS_ID) begin
               word_acc = {word_acc[23:0], b};
               if (off >= 7) begin
                  walk_halted = 1'b1;
                  walk_phase = WALK_KIND;
               end
            end else if (off <= 7) begin
               word_acc = {b, word_acc[31:8]};
            end else if (off == 8) begin
               port_acc = {8'h00, b};
            end else if (off == 9) begin
               port_acc = {b, port_acc[7:0]};
            end else begin
               flag_acc = b;
               walk_halted = 1'b1;
               walk_phase = WALK_KIND;
            end
         end
         default: ;
      endcase
      return 0;
   endfunction

   function automatic void walk_byte(input int unsigned p, input logic [7:0] b,
                                     input int unsigned lim);
      int replay;
      int unsigned s;
      logic [7:0] lo;
      replay = walk_one(p, b, lim);
      s = opt_start;
      lo = magic_acc[7:0];
      if (replay == 2)
         void'(walk_one(s + 2, lo, lim));
      if (replay >= 2)
         void'(walk_one(s + 3, b, lim));
   endfunction

   function automatic void predict_byte(input logic [7:0] b, input logic [5:0] len_field,
                                        input logic mark);
      int unsigned lim, p;
      logic [2:0] st;
      result_type r;
      if (mark)
         clear_walker();
      else if (walk_phase == WALK_DONE)
         return;
      lim = len_field;
      if (lim > DEFAULT_MAX_OPTION_BYTES)
         lim = DEFAULT_MAX_OPTION_BYTES;
      if (lim == 0)
         return;
      p = walk_pos;
      walk_byte(p, b, lim);
      if (p + 1 < lim) begin
         walk_pos = 6'(p + 1);
         return;
      end
      st = status_acc;
      if (!walk_halted && walk_phase == WALK_RECORD)
         st = STATUS_OVERRUN;
      r = '0;
      r.status = st;
      if (st == STATUS_ID)
         r.conn_id = word_acc;
      if (st == STATUS_PATH) begin
         r.path_address = word_acc;
         r.path_port = port_acc;
         r.path_priority = flag_acc[7:4];
         r.path_create = |(flag_acc & CREATE_BIT);
      end
      expected_results.push_back(r);
      walk_phase = WALK_DONE;
   endfunction

   task automatic send_byte(input logic [7:0] value, input logic [5:0] len_field,
                            input logic mark);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, MAX_GAP);
      repeat (gap) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
      @(negedge clock);
      req_bus.valid <= 1'b1;
      req_bus.opt_byte <= value;
      req_bus.area_len <= len_field;
      req_bus.first <= mark;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      predict_byte(value, len_field, mark);
      bytes_sent++;
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_OPTION_KIND:       parser_cfg.option_kind = value[7:0];
         CSR_INITIAL_MAGIC:     parser_cfg.initial_magic = value;
         CSR_NEW_PATH_MAGIC:    parser_cfg.new_path_magic = value;
         CSR_INITIAL_MIN_AREA:  parser_cfg.initial_min_area = value[5:0];
         CSR_NEW_PATH_MIN_AREA: parser_cfg.new_path_min_area = value[5:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic [7:0] kind, input logic [15:0] id_magic,
                                 input logic [15:0] path_magic, input logic [5:0] id_min,
                                 input logic [5:0] path_min);
      wait_for_results();
      write_register(CSR_OPTION_KIND, {8'h00, kind});
      write_register(CSR_INITIAL_MAGIC, id_magic);
      write_register(CSR_NEW_PATH_MAGIC, path_magic);
      write_register(CSR_INITIAL_MIN_AREA, {10'd0, id_min});
      write_register(CSR_NEW_PATH_MIN_AREA, {10'd0, path_min});
   endtask

   // Build a walkable area (NOPs, foreign options, extension records, end-of-list),
   // then send it with occasional clamped, changed or abandoned lengths and stray beats.
   task automatic send_area();
      logic [7:0]  area [0:63];
      logic [15:0] magic;
      logic [5:0]  len_field, late_len;
      int area_len, pos, pick, olen, k, count, cut_at;
      if ($urandom_range(0, 9) == 0)
         steady_flow = !steady_flow;
      if ($urandom_range(0, 29) == 0)
         send_byte(8'($urandom), 6'd0, 1'b1);
      pick = $urandom_range(0, 99);
      if (pick < 65)
         area_len = $urandom_range(4, 20);
      else if (pick < 85)
         area_len = $urandom_range(21, 40);
      else if (pick < 93)
         area_len = $urandom_range(1, 3);
      else
         area_len = DEFAULT_MAX_OPTION_BYTES;
      len_field = 6'(area_len);
      if (pick >= 96)
         len_field = 6'($urandom_range(41, 63));
      for (k = 0; k < 64; k++)
         area[k] = 8'($urandom);
      pos = 0;
      while (pos < area_len) begin
         pick = $urandom_range(0, 99);
         if (pick < 12) begin
            area[pos] = OPT_NOP;
            pos++;
         end else if (pick < 16) begin
            area[pos] = OPT_END;
            pos = area_len;
         end else begin
            if (pick < 40) begin
               area[pos] = 8'($urandom_range(2, 255));
               olen = $urandom_range(2, 8);
            end else begin
               pick = $urandom_range(0, 99);
               magic = (pick < 40) ? parser_cfg.initial_magic :
                       (pick < 80) ? parser_cfg.new_path_magic : 16'($urandom);
               olen = (pick < 40) ? int'(ID_RECORD_BYTES) :
                      (pick < 80) ? int'(PATH_RECORD_BYTES) : $urandom_range(2, 12);
               area[pos] = parser_cfg.option_kind;
               area[pos + 2] = magic[7:0];
               area[pos + 3] = magic[15:8];
            end
            if ($urandom_range(0, 9) == 0)
               olen = $urandom_range(0, 255);
            area[pos + 1] = 8'(olen);
            pos += (olen < 2) ? area_len : olen;
         end
      end
      count = area_len;
      cut_at = area_len;
      late_len = len_field;
      pick = $urandom_range(0, 99);
      if (pick < 6 && area_len > 1) begin
         cut_at = $urandom_range(1, area_len - 1);
         late_len = 6'($urandom_range(1, 40));
      end else if (pick < 10) begin
         count = $urandom_range(1, area_len);
      end
      for (k = 0; k < count; k++)
         send_byte(area[k], (k < cut_at) ? len_field : late_len, k == 0);
      if ($urandom_range(0, 15) == 0)
         repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 6'($urandom), 1'b0);
   endtask

   task automatic test_id_and_path_records();
      send_byte(parser_cfg.option_kind, 6'd8, 1'b1);
      send_byte(8'(ID_RECORD_BYTES), 6'd8, 1'b0);
      send_byte(parser_cfg.initial_magic[7:0], 6'd8, 1'b0);
      send_byte(parser_cfg.initial_magic[15:8], 6'd8, 1'b0);
      send_byte(8'hFF, 6'd8, 1'b0);
      send_byte(8'h00, 6'd8, 1'b0);
      send_byte(8'h80, 6'd8, 1'b0);
      send_byte(8'h7F, 6'd8, 1'b0);
      send_byte(parser_cfg.option_kind, 6'd11, 1'b1);
      send_byte(8'(PATH_RECORD_BYTES), 6'd11, 1'b0);
      send_byte(parser_cfg.new_path_magic[7:0], 6'd11, 1'b0);
      send_byte(parser_cfg.new_path_magic[15:8], 6'd11, 1'b0);
      send_byte(8'h00, 6'd11, 1'b0);
      send_byte(8'hFF, 6'd11, 1'b0);
      send_byte(8'h01, 6'd11, 1'b0);
      send_byte(8'hFE, 6'd11, 1'b0);
      send_byte(8'hFF, 6'd11, 1'b0);
      send_byte(8'h00, 6'd11, 1'b0);
      send_byte(8'hF8, 6'd11, 1'b0);
   endtask

   task automatic test_edge_bytes();
      // short extension option, stray beat, zero-length area, then a one-byte area
      send_byte(parser_cfg.option_kind, 6'd3, 1'b1);
      send_byte(8'd3, 6'd3, 1'b0);
      send_byte(8'hFF, 6'd3, 1'b0);
      send_byte(8'h00, 6'd63, 1'b0);
      send_byte(8'hA5, 6'd0, 1'b1);
      send_byte(8'hFF, 6'd1, 1'b0);
   endtask

   task automatic test_register_settings();
      int n;
      for (int phase_no = 0; phase_no < 6; phase_no++) begin
         case (phase_no)
            0: apply_settings(8'd255, 16'h0000, 16'hFFFF, 6'd0, 6'd40);
            1: apply_settings(8'd0, 16'h1234, 16'hABCD, 6'd40, 6'd0);
            2: apply_settings(8'd2, 16'h5A5A, 16'h5A5A, 6'd0, 6'd0);
            3: apply_settings(8'd30, 16'hC3C3, 16'hC3C3, 6'd8, 6'd40);
            4: apply_settings(8'($urandom_range(2, 255)), 16'($urandom), 16'($urandom),
                              6'($urandom_range(0, 40)), 6'($urandom_range(0, 40)));
            default: apply_settings(RST_OPTION_KIND, RST_INITIAL_MAGIC, RST_NEW_PATH_MAGIC,
                                    RST_INITIAL_MIN_AREA, RST_NEW_PATH_MIN_AREA);
         endcase
         for (n = 0; n < 6; n++)
            send_area();
      end
   endtask

   task automatic test_hold_until_drained();
      repeat (3) send_area();
      wait_for_results();
      repeat (3) send_area();
   endtask

   task automatic test_random_areas();
      while (bytes_sent < RANDOM_BYTES + DIRECTED_BYTES)
         send_area();
   endtask

   initial begin : result_monitor
      int hold;
      result_type got, want;
      hold = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            got.status = rsp_bus.status;
            got.conn_id = rsp_bus.conn_id;
            got.path_address = rsp_bus.path_address;
            got.path_port = rsp_bus.path_port;
            got.path_priority = rsp_bus.path_priority;
            got.path_create = rsp_bus.path_create;
            if (expected_results.size() == 0) begin
               fault_count++;
               if (fault_count <= REPORT_LIMIT)
                  $display("unexpected result beat: status %0d", got.status);
            end else begin
               want = expected_results.pop_front();
               if (got !== want) begin
                  fault_count++;
                  if (fault_count <= REPORT_LIMIT) begin
                     $display("mismatch: expected status %0d id %h addr %h port %h %h %b",
                              want.status, want.conn_id, want.path_address,
                              want.path_port, want.path_priority, want.path_create);
                     $display("          actual   status %0d id %h addr %h port %h %h %b",
                              got.status, got.conn_id, got.path_address,
                              got.path_port, got.path_priority, got.path_create);
                  end
               end
            end
            hold = steady_flow ? 0 : $urandom_range(0, MAX_GAP);
         end
         @(negedge clock);
         if (hold > 0) begin
            rsp_bus.ready <= 1'b0;
            hold--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      #3_000_000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      req_bus.valid = 1'b0;
      req_bus.opt_byte = '0;
      req_bus.area_len = '0;
      req_bus.first = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = CSR_OPTION_KIND;
      csr_wr_data = '0;
      parser_cfg.option_kind = RST_OPTION_KIND;
      parser_cfg.initial_magic = RST_INITIAL_MAGIC;
      parser_cfg.new_path_magic = RST_NEW_PATH_MAGIC;
      parser_cfg.initial_min_area = RST_INITIAL_MIN_AREA;
      parser_cfg.new_path_min_area = RST_NEW_PATH_MIN_AREA;
      clear_walker();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_id_and_path_records();
      test_edge_bytes();
      test_register_settings();
      test_hold_until_drained();
      test_random_areas();

      wait_for_results();
      fault_count += expected_results.size();
      if (fault_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
